>>> src/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the B-spline surface point evaluator.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int MAX_POINTS = 16;
  localparam int MAX_DEGREE = 3;
  localparam int IDX_W      = 4;
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int GRID_DEPTH = MAX_POINTS * MAX_POINTS;
  localparam int CNT_W      = 5;
  localparam int DEG_W      = 2;
  localparam int COORD_W    = 32;
  localparam int PARAM_W    = 17;
  localparam int BASIS_W    = 32;
  localparam int BASIS_FRAC = 30;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(65536);
  localparam logic [BASIS_W-1:0] BASIS_ONE = BASIS_W'(64'd1 << BASIS_FRAC);

  localparam logic [CFG_IDX_W-1:0] REG_U_POINTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_V_POINTS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_U_DEGREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_V_DEGREE = 3'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FEW   = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_EVAL,
    KIND_FAIL
  } kind_t;

  typedef struct packed {
    kind_t                      kind;
    logic [1:0]                 status;
    logic [ADDR_W-1:0]          addr;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
    logic [PARAM_W-1:0]         u;
    logic [PARAM_W-1:0]         v;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] m;
    logic [DEG_W-1:0] p;
    logic [DEG_W-1:0] q;
  } cfg_t;

  typedef logic [MAX_DEGREE:0][BASIS_W-1:0] basis_vec_t;

endpackage

>>> src/bsp_ram.sv
// ----------------------------------------------------------------------------
// bsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/bsp_queue.sv
// ----------------------------------------------------------------------------
// bsp_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module bsp_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bsp_pkg::item_t push_item,
  input  logic           pop,
  output bsp_pkg::item_t head,
  output logic           empty,
  output logic           full
);
  import bsp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_QW-1:0]  count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_QW'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> src/bsp_front.sv
// ----------------------------------------------------------------------------
// bsp_front
// Configuration registers, item intake and classification.
// ----------------------------------------------------------------------------
module bsp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               take,
  input  logic                               in_action,
  input  logic [bsp_pkg::IDX_W-1:0]          in_row,
  input  logic [bsp_pkg::IDX_W-1:0]          in_col,
  input  logic signed [bsp_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [bsp_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [bsp_pkg::COORD_W-1:0] in_point_z,
  input  logic [bsp_pkg::PARAM_W-1:0]        in_u_param,
  input  logic [bsp_pkg::PARAM_W-1:0]        in_v_param,
  output logic                               push,
  output bsp_pkg::item_t                     push_item,
  output bsp_pkg::cfg_t                      cfg
);
  import bsp_pkg::*;

  logic [CNT_W-1:0] u_points_r, v_points_r;
  logic [DEG_W-1:0] u_degree_r, v_degree_r;
  logic             few;
  logic             range_bad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_points_r <= CNT_W'(4);
      v_points_r <= CNT_W'(4);
      u_degree_r <= DEG_W'(3);
      v_degree_r <= DEG_W'(3);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_U_POINTS: u_points_r <= cfg_data;
        REG_V_POINTS: v_points_r <= cfg_data;
        REG_U_DEGREE: u_degree_r <= cfg_data[DEG_W-1:0];
        REG_V_DEGREE: v_degree_r <= cfg_data[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp counts to grid capacity
  always_comb begin
    cfg.n = (u_points_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : u_points_r;
    cfg.m = (v_points_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : v_points_r;
    cfg.p = u_degree_r;
    cfg.q = v_degree_r;
  end

  assign few = (cfg.n < CNT_W'(2)) || (cfg.m < CNT_W'(2)) ||
               (cfg.n <= CNT_W'(cfg.p)) || (cfg.m <= CNT_W'(cfg.q));
  assign range_bad = (in_u_param > PARAM_ONE) || (in_v_param > PARAM_ONE);

  assign push = take;

  always_comb begin
    push_item.addr = {in_row, in_col};
    push_item.x    = in_point_x;
    push_item.y    = in_point_y;
    push_item.z    = in_point_z;
    push_item.u    = in_u_param;
    push_item.v    = in_v_param;
    if (in_action == ACT_WRITE) begin
      push_item.kind   = KIND_WRITE;
      push_item.status = ST_OK;
    end else if (few) begin
      push_item.kind   = KIND_FAIL;
      push_item.status = ST_FEW;
    end else if (range_bad) begin
      push_item.kind   = KIND_FAIL;
      push_item.status = ST_RANGE;
    end else begin
      push_item.kind   = KIND_EVAL;
      push_item.status = ST_OK;
    end
  end

endmodule

>>> src/bsp_basis.sv
// ----------------------------------------------------------------------------
// bsp_basis
// Knot span and nonvanishing basis functions for one direction, with a
// two-lane radix-2 restoring divider shared by every recurrence step.
// ----------------------------------------------------------------------------
module bsp_basis (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [bsp_pkg::PARAM_W-1:0]   param,
  input  logic [bsp_pkg::CNT_W-1:0]     npts,
  input  logic [bsp_pkg::DEG_W-1:0]     deg,
  output logic                          done,
  output logic [bsp_pkg::IDX_W-1:0]     span,
  output bsp_pkg::basis_vec_t           nb
);
  import bsp_pkg::*;

  localparam int X_W   = 21;
  localparam int D_W   = 22;
  localparam int Q_W   = 34;
  localparam int NUM_W = 55;
  localparam int HI_W  = NUM_W - Q_W;
  localparam int C_W   = $clog2(Q_W);

  typedef enum logic [2:0] {B_IDLE, B_INIT, B_STEP, B_DIV, B_UPD} bstate_t;

  bstate_t            state_r;
  logic [PARAM_W-1:0] param_r;
  logic [CNT_W-1:0]   n_r;
  logic [DEG_W-1:0]   p_r, j_r, r_r;
  logic [X_W-1:0]     x_r;
  logic [IDX_W-1:0]   span_r;
  basis_vec_t         nb_r;
  logic [BASIS_W-1:0] saved_r;
  logic [D_W-1:0]     den_r, rem_a_r, rem_b_r;
  logic [Q_W-1:0]     low_a_r, low_b_r, q_a_r, q_b_r;
  logic [C_W-1:0]     cnt_r;
  logic               dz_r, done_r;

  logic [X_W-1:0]     lf, rt;
  logic [D_W-1:0]     den;
  logic [NUM_W-1:0]   num_a, num_b;
  logic [D_W:0]       sh_a, sh_b;
  logic [X_W+1:0]     x_full;
  logic [CNT_W-1:0]   span_lo;
  logic [BASIS_W-1:0] qa, qb;

  function automatic logic [X_W-1:0] knot(input int i, input int p, input int n);
    int t;
    t = i - p;
    if (t < 0) t = 0;
    if (t > n - p) t = n - p;
    return X_W'(t) << 16;
  endfunction

  assign done = done_r;
  assign span = span_r;
  assign nb   = nb_r;

  assign x_full  = (X_W + 2)'(param_r) * (X_W + 2)'(n_r - CNT_W'(p_r));
  assign span_lo = CNT_W'(p_r) + CNT_W'(x_full[X_W-1:16]);

  always_comb begin
    lf    = x_r - knot(int'(span_r) + 1 - (int'(j_r) - int'(r_r)), int'(p_r), int'(n_r));
    rt    = knot(int'(span_r) + int'(r_r) + 1, int'(p_r), int'(n_r)) - x_r;
    den   = D_W'(lf) + D_W'(rt);
    num_a = NUM_W'(rt) * NUM_W'(nb_r[r_r]) + NUM_W'(den >> 1);
    num_b = NUM_W'(lf) * NUM_W'(nb_r[r_r]) + NUM_W'(den >> 1);
    sh_a  = {rem_a_r, low_a_r[Q_W-1]};
    sh_b  = {rem_b_r, low_b_r[Q_W-1]};
    qa    = dz_r ? '0 : q_a_r[BASIS_W-1:0];
    qb    = dz_r ? '0 : q_b_r[BASIS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (go) begin
            param_r <= param;
            n_r     <= npts;
            p_r     <= deg;
            state_r <= B_INIT;
          end
        end
        B_INIT: begin
          x_r       <= x_full[X_W-1:0];
          span_r    <= (param_r == PARAM_ONE) ? IDX_W'(n_r - 1'b1) : span_lo[IDX_W-1:0];
          nb_r[0]   <= BASIS_ONE;
          saved_r   <= '0;
          j_r       <= DEG_W'(1);
          r_r       <= '0;
          if (p_r == '0) begin
            done_r  <= 1'b1;
            state_r <= B_IDLE;
          end else begin
            state_r <= B_STEP;
          end
        end
        B_STEP: begin
          den_r   <= den;
          dz_r    <= (den == '0);
          rem_a_r <= D_W'(num_a[NUM_W-1 -: HI_W]);
          rem_b_r <= D_W'(num_b[NUM_W-1 -: HI_W]);
          low_a_r <= num_a[Q_W-1:0];
          low_b_r <= num_b[Q_W-1:0];
          cnt_r   <= C_W'(Q_W - 1);
          state_r <= B_DIV;
        end
        B_DIV: begin
          // one quotient bit per lane per cycle
          if (sh_a >= {1'b0, den_r}) begin
            rem_a_r <= D_W'(sh_a - {1'b0, den_r});
            q_a_r   <= {q_a_r[Q_W-2:0], 1'b1};
          end else begin
            rem_a_r <= sh_a[D_W-1:0];
            q_a_r   <= {q_a_r[Q_W-2:0], 1'b0};
          end
          if (sh_b >= {1'b0, den_r}) begin
            rem_b_r <= D_W'(sh_b - {1'b0, den_r});
            q_b_r   <= {q_b_r[Q_W-2:0], 1'b1};
          end else begin
            rem_b_r <= sh_b[D_W-1:0];
            q_b_r   <= {q_b_r[Q_W-2:0], 1'b0};
          end
          low_a_r <= low_a_r << 1;
          low_b_r <= low_b_r << 1;
          cnt_r   <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= B_UPD;
          end
        end
        B_UPD: begin
          nb_r[r_r] <= saved_r + qa;
          if (r_r == j_r - 1'b1) begin
            nb_r[j_r] <= qb;
            saved_r   <= '0;
            r_r       <= '0;
            if (j_r == p_r) begin
              done_r  <= 1'b1;
              state_r <= B_IDLE;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= B_STEP;
            end
          end else begin
            saved_r <= qb;
            r_r     <= r_r + 1'b1;
            state_r <= B_STEP;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

>>> src/bsp_back.sv
// ----------------------------------------------------------------------------
// bsp_back
// Executes queued items: grid writes, error results and surface evaluation
// (basis per direction, then the weighted sum over the covered points).
// ----------------------------------------------------------------------------
module bsp_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bsp_pkg::cfg_t                       cfg,
  input  bsp_pkg::item_t                      head,
  input  logic                                q_empty,
  output logic                                pop,
  output logic                                out_strobe,
  output logic signed [bsp_pkg::COORD_W-1:0]  out_surf_x,
  output logic signed [bsp_pkg::COORD_W-1:0]  out_surf_y,
  output logic signed [bsp_pkg::COORD_W-1:0]  out_surf_z,
  output logic [1:0]                          out_status
);
  import bsp_pkg::*;

  localparam int PROD_W = COORD_W + BASIS_W + 1;
  localparam int COL_W  = PROD_W + 2;
  localparam int COLR_W = 36;
  localparam int HALF_W = COLR_W / 2;
  localparam int PV_W   = BASIS_W + HALF_W + 1;
  localparam int ACC_W  = 72;
  localparam int OUT_W  = ACC_W - BASIS_FRAC;
  localparam logic signed [COL_W-1:0] COL_HALF = COL_W'(64'd1 << (BASIS_FRAC - 1));
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'd1 << (BASIS_FRAC - 1));
  localparam logic signed [OUT_W-1:0] OUT_MAX  = OUT_W'(64'sd2147483647);
  localparam logic signed [OUT_W-1:0] OUT_MIN  = -OUT_W'(64'sd2147483648);

  typedef enum logic [3:0] {
    S_IDLE, S_BU, S_WU, S_BV, S_WV, S_RD, S_MUL, S_ACC, S_RND,
    S_VLO, S_VHI, S_VACC, S_OUT
  } state_t;

  state_t                    state_r;
  logic [PARAM_W-1:0]        u_r, v_r;
  basis_vec_t                nu_r, nv_r;
  logic [IDX_W-1:0]          us_r, vs_r;
  logic [DEG_W-1:0]          k_r, l_r;
  logic signed [PROD_W-1:0]  prod_r [3];
  logic signed [COL_W-1:0]   col_r [3];
  logic signed [COLR_W-1:0]  colr_r [3];
  logic signed [PV_W-1:0]    plo_r [3];
  logic signed [PV_W-1:0]    phi_r [3];
  logic signed [ACC_W-1:0]   acc_r [3];
  logic                      strobe_r;
  logic signed [COORD_W-1:0] sx_r, sy_r, sz_r;
  logic [1:0]                status_r;

  logic                      ram_we;
  logic [ADDR_W-1:0]         raddr;
  logic [COORD_W-1:0]        rdata [3];
  logic                      b_go, b_done;
  logic [PARAM_W-1:0]        b_param;
  logic [CNT_W-1:0]          b_npts;
  logic [DEG_W-1:0]          b_deg;
  logic [IDX_W-1:0]          b_span;
  basis_vec_t                b_nb;
  logic [IDX_W-1:0]          rr, cc;
  logic signed [COL_W-1:0]   col_sum [3];
  logic signed [ACC_W-1:0]   acc_sum [3];
  logic signed [OUT_W-1:0]   res [3];
  logic signed [COORD_W-1:0] sat [3];

  assign pop    = (state_r == S_IDLE) && !q_empty;
  assign ram_we = pop && (head.kind == KIND_WRITE);
  assign rr     = us_r - IDX_W'(cfg.p) + IDX_W'(k_r);
  assign cc     = vs_r - IDX_W'(cfg.q) + IDX_W'(l_r);
  assign raddr  = {rr, cc};

  assign b_go    = (state_r == S_BU) || (state_r == S_BV);
  assign b_param = (state_r == S_BU) ? u_r : v_r;
  assign b_npts  = (state_r == S_BU) ? cfg.n : cfg.m;
  assign b_deg   = (state_r == S_BU) ? cfg.p : cfg.q;

  bsp_ram #(.WIDTH(COORD_W), .DEPTH(GRID_DEPTH)) u_ram_x (
    .clk(clk), .we(ram_we), .waddr(head.addr), .wdata(head.x),
    .raddr(raddr), .rdata(rdata[0])
  );
  bsp_ram #(.WIDTH(COORD_W), .DEPTH(GRID_DEPTH)) u_ram_y (
    .clk(clk), .we(ram_we), .waddr(head.addr), .wdata(head.y),
    .raddr(raddr), .rdata(rdata[1])
  );
  bsp_ram #(.WIDTH(COORD_W), .DEPTH(GRID_DEPTH)) u_ram_z (
    .clk(clk), .we(ram_we), .waddr(head.addr), .wdata(head.z),
    .raddr(raddr), .rdata(rdata[2])
  );

  bsp_basis u_basis (
    .clk(clk), .rst_n(rst_n), .go(b_go), .param(b_param), .npts(b_npts),
    .deg(b_deg), .done(b_done), .span(b_span), .nb(b_nb)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      col_sum[i] = col_r[i] + COL_HALF;
      acc_sum[i] = acc_r[i] + ACC_HALF;
      res[i]     = OUT_W'(acc_sum[i] >>> BASIS_FRAC);
      if (res[i] > OUT_MAX) begin
        sat[i] = COORD_W'(OUT_MAX);
      end else if (res[i] < OUT_MIN) begin
        sat[i] = COORD_W'(OUT_MIN);
      end else begin
        sat[i] = COORD_W'(res[i]);
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_surf_x = sx_r;
  assign out_surf_y = sy_r;
  assign out_surf_z = sz_r;
  assign out_status = status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            unique case (head.kind)
              KIND_WRITE: ;
              KIND_FAIL: begin
                strobe_r <= 1'b1;
                sx_r     <= '0;
                sy_r     <= '0;
                sz_r     <= '0;
                status_r <= head.status;
              end
              KIND_EVAL: begin
                u_r     <= head.u;
                v_r     <= head.v;
                state_r <= S_BU;
              end
              default: ;
            endcase
          end
        end
        S_BU: state_r <= S_WU;
        S_WU: begin
          if (b_done) begin
            nu_r    <= b_nb;
            us_r    <= b_span;
            state_r <= S_BV;
          end
        end
        S_BV: state_r <= S_WV;
        S_WV: begin
          if (b_done) begin
            nv_r    <= b_nb;
            vs_r    <= b_span;
            k_r     <= '0;
            l_r     <= '0;
            for (int i = 0; i < 3; i++) begin
              col_r[i] <= '0;
              acc_r[i] <= '0;
            end
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_MUL;
        S_MUL: begin
          for (int i = 0; i < 3; i++) begin
            prod_r[i] <= $signed({1'b0, nu_r[k_r]}) * $signed(rdata[i]);
          end
          state_r <= S_ACC;
        end
        S_ACC: begin
          for (int i = 0; i < 3; i++) begin
            col_r[i] <= col_r[i] + COL_W'(prod_r[i]);
          end
          if (k_r == cfg.p) begin
            state_r <= S_RND;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_RND: begin
          for (int i = 0; i < 3; i++) begin
            colr_r[i] <= COLR_W'(col_sum[i] >>> BASIS_FRAC);
          end
          state_r <= S_VLO;
        end
        S_VLO: begin
          for (int i = 0; i < 3; i++) begin
            plo_r[i] <= $signed({1'b0, nv_r[l_r]}) *
                        $signed({1'b0, colr_r[i][HALF_W-1:0]});
          end
          state_r <= S_VHI;
        end
        S_VHI: begin
          for (int i = 0; i < 3; i++) begin
            phi_r[i] <= $signed({1'b0, nv_r[l_r]}) *
                        $signed(colr_r[i][COLR_W-1:HALF_W]);
          end
          state_r <= S_VACC;
        end
        S_VACC: begin
          for (int i = 0; i < 3; i++) begin
            acc_r[i] <= acc_r[i] + ACC_W'(plo_r[i]) + (ACC_W'(phi_r[i]) <<< HALF_W);
            col_r[i] <= '0;
          end
          k_r <= '0;
          if (l_r == cfg.q) begin
            state_r <= S_OUT;
          end else begin
            l_r     <= l_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_OUT: begin
          strobe_r <= 1'b1;
          sx_r     <= sat[0];
          sy_r     <= sat[1];
          sz_r     <= sat[2];
          status_r <= ST_OK;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/bspline_surface_point_eval_top.sv
// ----------------------------------------------------------------------------
// bspline_surface_point_eval_top
// Tensor-product B-spline surface point evaluator with a control-point grid.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------
//  in_      | in_start / busy           | action, row, col, point xyz, u, v
//  out_     | out_strobe (one cycle)    | surf xyz, status
//  cfg_     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  An accepted item enters a QUEUE_DEPTH queue; busy is high while it is full.
//  A write reaches the grid as it is popped; an error result is registered and
//  strobed after the back end pops it from the queue head. An evaluation runs
//  deg*(deg+1)/2 basis recurrence steps per direction through the 34-bit
//  radix-2 divider, then weights every covered point and each v column.
//  Reset is synchronous; the grid holds no reset value. Results cannot be
//  stalled.
// ----------------------------------------------------------------------------
module bspline_surface_point_eval_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_start,
  output logic                               busy,
  input  logic                               in_action,
  input  logic [bsp_pkg::IDX_W-1:0]          in_row,
  input  logic [bsp_pkg::IDX_W-1:0]          in_col,
  input  logic signed [bsp_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [bsp_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [bsp_pkg::COORD_W-1:0] in_point_z,
  input  logic [bsp_pkg::PARAM_W-1:0]        in_u_param,
  input  logic [bsp_pkg::PARAM_W-1:0]        in_v_param,
  output logic                               out_strobe,
  output logic signed [bsp_pkg::COORD_W-1:0] out_surf_x,
  output logic signed [bsp_pkg::COORD_W-1:0] out_surf_y,
  output logic signed [bsp_pkg::COORD_W-1:0] out_surf_z,
  output logic [1:0]                         out_status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bsp_pkg::*;

  logic  push, pop, q_empty, q_full;
  item_t push_item, head;
  cfg_t  cfg;

  assign busy = q_full;

  bsp_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .take(in_start && !q_full),
    .in_action(in_action), .in_row(in_row), .in_col(in_col),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_u_param(in_u_param), .in_v_param(in_v_param),
    .push(push), .push_item(push_item), .cfg(cfg)
  );

  bsp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item),
    .pop(pop), .head(head), .empty(q_empty), .full(q_full)
  );

  bsp_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .head(head), .q_empty(q_empty),
    .pop(pop), .out_strobe(out_strobe), .out_surf_x(out_surf_x),
    .out_surf_y(out_surf_y), .out_surf_z(out_surf_z), .out_status(out_status)
  );

endmodule

>>> tb/bspline_surface_point_eval_top_tb.sv
// ----------------------------------------------------------------------------
// bspline_surface_point_eval_top_tb
// Self-checking bench for the B-spline surface point evaluator: fills the
// control-point grid, sweeps point counts and degrees through their extremes,
// evaluates random and corner parameters and compares every surface point
// with a cycle-free fixed-point prediction kept in a small scoreboard.
// ----------------------------------------------------------------------------
module bspline_surface_point_eval_top_tb;
  import bsp_pkg::*;

  localparam int DRAIN_CYCLES = 600;
  localparam int STALL_LIMIT  = 20000;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [1:0]                st;
  } surf_point_t;

  class surface_predictor;
    longint            grid[3][GRID_DEPTH];
    logic [CNT_W-1:0]  u_cnt, v_cnt;
    logic [DEG_W-1:0]  u_deg, v_deg;
    surf_point_t       pending_points[$];
    int                errors;

    function new();
      u_cnt = 4; v_cnt = 4; u_deg = 3; v_deg = 3;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_U_POINTS: u_cnt = val;
        REG_V_POINTS: v_cnt = val;
        REG_U_DEGREE: u_deg = val[DEG_W-1:0];
        REG_V_DEGREE: v_deg = val[DEG_W-1:0];
        default: ;
      endcase
    endfunction

    function longint knot(int i, int p, int n);
      int t;
      t = i - p;
      if (t < 0) t = 0;
      if (t > n - p) t = n - p;
      return longint'(t) * 65536;
    endfunction

    function int span_basis(longint prm, int n, int p, output longint nb[MAX_DEGREE+1]);
      longint x, saved, d, a, b;
      longint lft[MAX_DEGREE+1], rgt[MAX_DEGREE+1];
      int span;
      x = prm * (n - p);
      span = (prm >= 65536) ? n - 1 : p + int'(x / 65536);
      nb[0] = longint'(1) << BASIS_FRAC;
      for (int j = 1; j <= p; j++) begin
        saved = 0;
        lft[j] = x - knot(span + 1 - j, p, n);
        rgt[j] = knot(span + j, p, n) - x;
        for (int r = 0; r < j; r++) begin
          d = rgt[r+1] + lft[j-r];
          a = 0; b = 0;
          if (d != 0) begin
            a = (rgt[r+1] * nb[r] + d / 2) / d;
            b = (lft[j-r] * nb[r] + d / 2) / d;
          end
          nb[r] = saved + a;
          saved = b;
        end
        nb[j] = saved;
      end
      return span;
    endfunction

    // half-up rounding from Q.30 is a plain arithmetic shift after the bias
    function longint round30(longint v);
      return (v + (longint'(1) << 29)) >>> 30;
    endfunction

    function logic signed [COORD_W-1:0] blend(int a, longint nu[MAX_DEGREE+1],
        longint nv[MAX_DEGREE+1], int us, int vs, int p, int q);
      longint acc, col;
      acc = 0;
      for (int l = 0; l <= q; l++) begin
        col = 0;
        for (int k = 0; k <= p; k++)
          col += nu[k] * grid[a][(us - p + k) * MAX_POINTS + (vs - q + l)];
        acc += nv[l] * round30(col);
      end
      acc = round30(acc);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc[COORD_W-1:0];
    endfunction

    function void note_item(logic act, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
        logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
        logic signed [COORD_W-1:0] pz, logic [PARAM_W-1:0] u, logic [PARAM_W-1:0] v);
      surf_point_t e;
      longint nu[MAX_DEGREE+1], nv[MAX_DEGREE+1];
      int n, m, p, q, us, vs;
      if (act == ACT_WRITE) begin
        grid[0][{r, c}] = px;
        grid[1][{r, c}] = py;
        grid[2][{r, c}] = pz;
        return;
      end
      n = (u_cnt > MAX_POINTS) ? MAX_POINTS : u_cnt;
      m = (v_cnt > MAX_POINTS) ? MAX_POINTS : v_cnt;
      p = u_deg; q = v_deg;
      e.x = '0; e.y = '0; e.z = '0;
      if (n < 2 || m < 2 || n <= p || m <= q) e.st = ST_FEW;
      else if (u > PARAM_ONE || v > PARAM_ONE) e.st = ST_RANGE;
      else begin
        e.st = ST_OK;
        us = span_basis(longint'(u), n, p, nu);
        vs = span_basis(longint'(v), m, q, nv);
        e.x = blend(0, nu, nv, us, vs, p, q);
        e.y = blend(1, nu, nv, us, vs, p, q);
        e.z = blend(2, nu, nv, us, vs, p, q);
      end
      pending_points.insert(pending_points.size(), e);
    endfunction

    function void check_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
        logic signed [COORD_W-1:0] z, logic [1:0] st);
      surf_point_t e;
      if (pending_points.size() == 0) begin
        $display("%0t unexpected result x %0d y %0d z %0d status %0d", $time, x, y, z, st);
        errors++;
        return;
      end
      e = pending_points.pop_front();
      if (st !== e.st) begin
        $display("%0t status exp %0d act %0d", $time, e.st, st); errors++;
      end
      if (x !== e.x) begin
        $display("%0t surf_x exp %0d act %0d", $time, e.x, x); errors++;
      end
      if (y !== e.y) begin
        $display("%0t surf_y exp %0d act %0d", $time, e.y, y); errors++;
      end
      if (z !== e.z) begin
        $display("%0t surf_z exp %0d act %0d", $time, e.z, z); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_start, busy, in_action;
  logic [IDX_W-1:0] in_row, in_col;
  logic signed [COORD_W-1:0] in_point_x, in_point_y, in_point_z;
  logic [PARAM_W-1:0] in_u_param, in_v_param;
  logic out_strobe;
  logic signed [COORD_W-1:0] out_surf_x, out_surf_y, out_surf_z;
  logic [1:0] out_status;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  surface_predictor model = new();
  int send_idle_pct;
  int stall_cycles;

  bspline_surface_point_eval_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) model.check_point(out_surf_x, out_surf_y, out_surf_z, out_status);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  task automatic send_item(logic act, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
      logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
      logic signed [COORD_W-1:0] pz, logic [PARAM_W-1:0] u, logic [PARAM_W-1:0] v);
    in_start <= 1'b1;
    in_action <= act; in_row <= r; in_col <= c;
    in_point_x <= px; in_point_y <= py; in_point_z <= pz;
    in_u_param <= u; in_v_param <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    model.note_item(act, r, c, px, py, pz, u, v);
    // insert a random gap, holding start low
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // valid stays high for a following write; the caller drops it after the last
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model.set_reg(idx, val);
  endtask

  // hold off until every result is back and trailing writes have drained
  task automatic drain();
    in_start <= 1'b0;
    while (model.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed(32'($urandom_range(0, 2000000))) - 32'sd1000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PARAM_W-1:0] pick_param();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return PARAM_ONE;
      2: return PARAM_W'($urandom_range(65537, 131071));
      default: return PARAM_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic random_item();
    if ($urandom_range(0, 99) < 70)
      send_item(ACT_EVAL, IDX_W'($urandom), IDX_W'($urandom), $urandom, $urandom,
                $urandom, pick_param(), pick_param());
    else
      send_item(ACT_WRITE, IDX_W'($urandom), IDX_W'($urandom), pick_coord(),
                pick_coord(), pick_coord(), PARAM_W'($urandom), PARAM_W'($urandom));
  endtask

  int ph_n[8] = '{2, 16, 31, 3, 16, 7, 1, 5};
  int ph_m[8] = '{2, 16, 0, 3, 5, 9, 4, 16};
  int ph_p[8] = '{1, 3, 2, 3, 0, 2, 1, 3};
  int ph_q[8] = '{1, 3, 0, 1, 2, 3, 1, 0};

  initial begin
    rst_n = 1'b0; in_start = 1'b0; in_action = 1'b0; in_row = '0; in_col = '0;
    in_point_x = '0; in_point_y = '0; in_point_z = '0; in_u_param = '0; in_v_param = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    stall_cycles = 0;
    send_idle_pct = 21;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole grid so no evaluation reads an unwritten entry
    for (int i = 0; i < GRID_DEPTH; i++)
      send_item(ACT_WRITE, i[7:4], i[3:0], pick_coord(), pick_coord(), pick_coord(),
                PARAM_W'($urandom), PARAM_W'($urandom));

    // corners under the reset setting
    send_item(ACT_EVAL, '0, '0, '0, '0, '0, '0, '0);
    send_item(ACT_EVAL, '0, '0, '0, '0, '0, PARAM_ONE, PARAM_ONE);
    send_item(ACT_EVAL, '0, '0, '0, '0, '0, PARAM_ONE, '0);
    send_item(ACT_EVAL, '0, '0, '0, '0, '0, 17'd32768, 17'd49152);
    send_item(ACT_EVAL, '0, '0, '0, '0, '0, 17'd65537, 17'd100);
    send_item(ACT_EVAL, '0, '0, '0, '0, '0, 17'd100, 17'h1ffff);
    send_item(ACT_EVAL, '0, '0, '0, '0, '0, 17'h1ffff, 17'h1ffff);
    send_item(ACT_WRITE, 4'd15, 4'd15, 32'sh7fffffff, 32'sh80000000, '0, '0, '0);
    send_item(ACT_WRITE, 4'd0, 4'd0, 32'sh80000000, 32'sh7fffffff, -32'sd1, '0, '0);
    send_item(ACT_EVAL, '0, '0, '0, '0, '0, 17'd1, 17'd65535);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = (ph < 3) ? 21 : (ph < 6) ? 84 : 0;
      write_reg(REG_U_POINTS, CFG_DATA_W'(ph_n[ph]));
      write_reg(REG_V_POINTS, CFG_DATA_W'(ph_m[ph]));
      write_reg(REG_U_DEGREE, CFG_DATA_W'(ph_p[ph]));
      write_reg(REG_V_DEGREE, CFG_DATA_W'(ph_q[ph]));
      write_reg(3'd7, 5'd31);
      cfg_valid <= 1'b0;
      for (int i = 0; i < 170; i++) random_item();
      drain();
    end

    if (model.errors == 0 && model.pending_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
